// ===== hdl/romanized_to_hangul_syllable_defines.svh =====
// assertion macros for the romanized to hangul syllable block
`ifndef ROMANIZED_TO_HANGUL_SYLLABLE_DEFINES_SVH
`define ROMANIZED_TO_HANGUL_SYLLABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RTHS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rths: implication check failed");

// delayed implication, disabled while reset is low
`define RTHS_ASSERT_LATER2(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
		else $error("rths: delayed check failed");

`endif

// ===== hdl/rths_pkg.sv =====
// types, constants and jamo match functions for the hangul syllable block
package rths_pkg;

	localparam int VOW_LANES  = 3;
	localparam int TAIL_LANES = 5;

	localparam logic [15:0] SYL_BASE   = 16'd44032;
	localparam logic [15:0] LEAD_SPAN  = 16'd588;
	localparam logic [15:0] VOWEL_SPAN = 16'd28;

	// result of one jamo match: hit flag, jamo index, bytes consumed
	typedef struct packed {
		logic       hit;
		logic [4:0] idx;
		logic [1:0] adv;
	} match_t;

	function automatic match_t mk(input logic [4:0] idx, input logic [1:0] adv);
		match_t m;
		m.hit = 1'b1;
		m.idx = idx;
		m.adv = adv;
		return m;
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A)
			r = c - 8'h20;
		return r;
	endfunction

	// lead consonant, longest patterns first; a vowel letter gives the silent lead
	function automatic match_t lead_match(input logic [7:0] c0, input logic [7:0] c1);
		match_t m;
		m = '0;
		if      ({c0, c1} == "GG") m = mk(5'd2, 2'd2);
		else if ({c0, c1} == "DD") m = mk(5'd5, 2'd2);
		else if ({c0, c1} == "BB") m = mk(5'd9, 2'd2);
		else if ({c0, c1} == "SS") m = mk(5'd11, 2'd2);
		else if ({c0, c1} == "JJ") m = mk(5'd14, 2'd2);
		else if (c0 == "G") m = mk(5'd1, 2'd1);
		else if (c0 == "N") m = mk(5'd3, 2'd1);
		else if (c0 == "D") m = mk(5'd4, 2'd1);
		else if (c0 == "R") m = mk(5'd6, 2'd1);
		else if (c0 == "M") m = mk(5'd7, 2'd1);
		else if (c0 == "B") m = mk(5'd8, 2'd1);
		else if (c0 == "S") m = mk(5'd10, 2'd1);
		else if (c0 == "J") m = mk(5'd13, 2'd1);
		else if (c0 == "C") m = mk(5'd15, 2'd1);
		else if (c0 == "K") m = mk(5'd16, 2'd1);
		else if (c0 == "T") m = mk(5'd17, 2'd1);
		else if (c0 == "P") m = mk(5'd18, 2'd1);
		else if (c0 == "H") m = mk(5'd19, 2'd1);
		else if (c0 == "A" || c0 == "Y" || c0 == "E" || c0 == "O" ||
			c0 == "W" || c0 == "U" || c0 == "I")
			m = mk(5'd12, 2'd0);
		return m;
	endfunction

	// medial vowel, three-letter patterns first
	function automatic match_t vow_match(input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2);
		match_t m;
		m = '0;
		if      ({c0, c1, c2} == "YAE") m = mk(5'd4, 2'd3);
		else if ({c0, c1, c2} == "YEO") m = mk(5'd7, 2'd3);
		else if ({c0, c1, c2} == "WAE") m = mk(5'd11, 2'd3);
		else if ({c0, c1, c2} == "WEO") m = mk(5'd15, 2'd3);
		else if ({c0, c1} == "AE") m = mk(5'd2, 2'd2);
		else if ({c0, c1} == "YA") m = mk(5'd3, 2'd2);
		else if ({c0, c1} == "EO") m = mk(5'd5, 2'd2);
		else if ({c0, c1} == "YE") m = mk(5'd8, 2'd2);
		else if ({c0, c1} == "WA") m = mk(5'd10, 2'd2);
		else if ({c0, c1} == "OE") m = mk(5'd12, 2'd2);
		else if ({c0, c1} == "YO") m = mk(5'd13, 2'd2);
		else if ({c0, c1} == "WE") m = mk(5'd16, 2'd2);
		else if ({c0, c1} == "WI") m = mk(5'd17, 2'd2);
		else if ({c0, c1} == "YU") m = mk(5'd18, 2'd2);
		else if ({c0, c1} == "EU") m = mk(5'd19, 2'd2);
		else if ({c0, c1} == "YI") m = mk(5'd20, 2'd2);
		else if (c0 == "A") m = mk(5'd1, 2'd1);
		else if (c0 == "E") m = mk(5'd6, 2'd1);
		else if (c0 == "O") m = mk(5'd9, 2'd1);
		else if (c0 == "U") m = mk(5'd14, 2'd1);
		else if (c0 == "I") m = mk(5'd21, 2'd1);
		return m;
	endfunction

	// final consonant; an empty string here is a hit with index zero
	function automatic match_t tail_match(input logic [7:0] c0, input logic [7:0] c1);
		match_t m;
		m = '0;
		if      (c0 == 8'h00) m = mk(5'd0, 2'd0);
		else if ({c0, c1} == "GG") m = mk(5'd2, 2'd2);
		else if ({c0, c1} == "GS") m = mk(5'd3, 2'd2);
		else if ({c0, c1} == "NJ") m = mk(5'd5, 2'd2);
		else if ({c0, c1} == "NH") m = mk(5'd6, 2'd2);
		else if ({c0, c1} == "LG") m = mk(5'd9, 2'd2);
		else if ({c0, c1} == "LM") m = mk(5'd10, 2'd2);
		else if ({c0, c1} == "LB") m = mk(5'd11, 2'd2);
		else if ({c0, c1} == "LS") m = mk(5'd12, 2'd2);
		else if ({c0, c1} == "LT") m = mk(5'd13, 2'd2);
		else if ({c0, c1} == "LP") m = mk(5'd14, 2'd2);
		else if ({c0, c1} == "LH") m = mk(5'd15, 2'd2);
		else if ({c0, c1} == "BS") m = mk(5'd18, 2'd2);
		else if ({c0, c1} == "SS") m = mk(5'd20, 2'd2);
		else if ({c0, c1} == "NG") m = mk(5'd21, 2'd2);
		else if (c0 == "G") m = mk(5'd1, 2'd1);
		else if (c0 == "N") m = mk(5'd4, 2'd1);
		else if (c0 == "D") m = mk(5'd7, 2'd1);
		else if (c0 == "L") m = mk(5'd8, 2'd1);
		else if (c0 == "M") m = mk(5'd16, 2'd1);
		else if (c0 == "B") m = mk(5'd17, 2'd1);
		else if (c0 == "S") m = mk(5'd19, 2'd1);
		else if (c0 == "J") m = mk(5'd22, 2'd1);
		else if (c0 == "C") m = mk(5'd23, 2'd1);
		else if (c0 == "K") m = mk(5'd24, 2'd1);
		else if (c0 == "T") m = mk(5'd25, 2'd1);
		else if (c0 == "P") m = mk(5'd26, 2'd1);
		else if (c0 == "H") m = mk(5'd27, 2'd1);
		return m;
	endfunction

endpackage

// ===== hdl/rths_vow_lane.sv =====
// vowel matcher lane at one fixed start position
module rths_vow_lane (
	input  logic [7:0]       c0,
	input  logic [7:0]       c1,
	input  logic [7:0]       c2,
	output rths_pkg::match_t m
);
	import rths_pkg::*;

	// table match on three uppercased bytes
	always_comb begin
		m = vow_match(c0, c1, c2);
	end

endmodule

// ===== hdl/rths_tail_lane.sv =====
// final consonant matcher lane at one fixed start position
module rths_tail_lane (
	input  logic [7:0]       c0,
	input  logic [7:0]       c1,
	output rths_pkg::match_t m
);
	import rths_pkg::*;

	// table match on two uppercased bytes
	always_comb begin
		m = tail_match(c0, c1);
	end

endmodule

// ===== hdl/rths_merge.sv =====
// picks the lanes along the parse path and composes the code point
module rths_merge (
	input  rths_pkg::match_t  lead,
	input  rths_pkg::match_t  vow  [rths_pkg::VOW_LANES],
	input  rths_pkg::match_t  tail [rths_pkg::TAIL_LANES],
	output logic              ok,
	output logic [15:0]       code
);
	import rths_pkg::*;

	match_t     v_sel;
	match_t     t_sel;
	logic [2:0] tail_pos;
	logic [15:0] lead_off;
	logic [15:0] vow_off;

	// vowel lane chosen by the lead length
	always_comb begin
		case (lead.adv)
			2'd1:    v_sel = vow[1];
			2'd2:    v_sel = vow[2];
			default: v_sel = vow[0];
		endcase
	end

	// tail lane chosen by lead plus vowel length
	assign tail_pos = {1'b0, lead.adv} + {1'b0, v_sel.adv};

	always_comb begin
		case (tail_pos)
			3'd2:    t_sel = tail[1];
			3'd3:    t_sel = tail[2];
			3'd4:    t_sel = tail[3];
			3'd5:    t_sel = tail[4];
			default: t_sel = tail[0];
		endcase
	end

	// syllable arithmetic
	assign lead_off = 16'(lead.idx - 5'd1) * LEAD_SPAN;
	assign vow_off  = 16'(v_sel.idx - 5'd1) * VOWEL_SPAN;
	assign ok       = lead.hit & v_sel.hit & t_sel.hit;
	assign code     = ok ? (SYL_BASE + lead_off + vow_off + 16'(t_sel.idx)) : 16'd0;

endmodule

// ===== hdl/romanized_to_hangul_syllable.sv =====
// romanized syllable to hangul code point: lanes, registered matches, merge
// a beat taken at start reaches strobe via the valid_s1 and valid_s2 registers
// throughput: one beat per cycle; busy is never raised and there is no stall
// stage 1 runs all vowel and tail lanes at every possible position, stage 2 merges
// reset: arst_n clears the stage valid flags at once; no result is shown until
// a new beat has passed both stages
module romanized_to_hangul_syllable (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  char_0,
	input  logic [7:0]  char_1,
	input  logic [7:0]  char_2,
	input  logic [7:0]  char_3,
	input  logic [7:0]  char_4,
	input  logic [7:0]  char_5,
	input  logic [7:0]  char_6,
	output logic        strobe,
	output logic [15:0] code_point,
	output logic        valid_res
);
	import rths_pkg::*;

	`include "romanized_to_hangul_syllable_defines.svh"

	logic [7:0]  up [7];
	match_t      lead_c;
	match_t      vow_c  [VOW_LANES];
	match_t      tail_c [TAIL_LANES];
	match_t      lead_s1;
	match_t      vow_s1  [VOW_LANES];
	match_t      tail_s1 [TAIL_LANES];
	logic        valid_s1;
	logic        ok_c;
	logic [15:0] code_c;
	logic        valid_s2;
	logic        ok_s2;
	logic [15:0] code_s2;

	assign busy = 1'b0;

	// uppercase the incoming bytes
	assign up[0] = upcase(char_0);
	assign up[1] = upcase(char_1);
	assign up[2] = upcase(char_2);
	assign up[3] = upcase(char_3);
	assign up[4] = upcase(char_4);
	assign up[5] = upcase(char_5);
	assign up[6] = upcase(char_6);

	// lead is always at position zero
	assign lead_c = lead_match(up[0], up[1]);

	// vowel lanes at positions zero to two
	for (genvar g = 0; g < VOW_LANES; g++) begin : g_vow
		rths_vow_lane u_vow (
			.c0 (up[g]),
			.c1 (up[g + 1]),
			.c2 (up[g + 2]),
			.m  (vow_c[g])
		);
	end

	// tail lanes at positions one to five
	for (genvar g = 0; g < TAIL_LANES; g++) begin : g_tail
		rths_tail_lane u_tail (
			.c0 (up[g + 1]),
			.c1 (up[g + 2]),
			.m  (tail_c[g])
		);
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	// stage 1 lane results
	always_ff @(posedge clk) begin
		lead_s1 <= lead_c;
		vow_s1  <= vow_c;
		tail_s1 <= tail_c;
	end

	rths_merge u_merge (
		.lead (lead_s1),
		.vow  (vow_s1),
		.tail (tail_s1),
		.ok   (ok_c),
		.code (code_c)
	);

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 result beat
	always_ff @(posedge clk) begin
		ok_s2   <= ok_c;
		code_s2 <= code_c;
	end

	assign strobe     = valid_s2;
	assign valid_res  = valid_s2 & ok_s2;
	assign code_point = valid_s2 ? code_s2 : 16'd0;

	// checks
	`RTHS_ASSERT_LATER2(a_beat_to_result, clk, arst_n, start && !busy, strobe)
	`RTHS_ASSERT_IMPLY(a_valid_has_strobe, clk, arst_n, valid_res, strobe)
	`RTHS_ASSERT_IMPLY(a_fail_zero, clk, arst_n, strobe && !valid_res, code_point == 16'd0)
	`RTHS_ASSERT_IMPLY(a_ok_range, clk, arst_n, valid_res,
		code_point >= 16'hAC00 && code_point <= 16'hD7A3)

endmodule
